/* hdl/mfps_pkg.sv */
// shared types, constants and helpers of the metaball field pixel shader
// no dependencies
package mfps_pkg;

    localparam int NUM_BALLS   = 3;
    localparam int COORD_W     = 4;
    localparam int CENTRE_W    = 12;
    localparam int DELTA_W     = CENTRE_W + 1;
    localparam int SQ_W        = 24;
    localparam int DEN_W       = 26;
    localparam int Q_W         = 17;
    localparam int DIV_STEPS   = Q_W;
    localparam int SUM_W       = Q_W + 2;
    localparam int LEVEL_W     = SUM_W - 8;

    // 1260 * 2^24 = REM_INIT * 2^17 with a zero low part
    localparam logic [DEN_W-1:0] REM_INIT = DEN_W'(1260 * 128);
    localparam logic [DEN_W-1:0] DEN_BIAS = DEN_W'(4 * 65536);
    localparam logic [LEVEL_W-1:0] DARK_LEVEL = LEVEL_W'(40);
    localparam logic [7:0] MAX_LEVEL  = 8'd255;
    localparam logic [7:0] HUE_SECTOR = 8'd43;
    localparam logic [16:0] RECIP_255 = 17'd32897;

    localparam logic [2:0] REG_HUE_OFFSET = 3'd0;
    localparam logic [2:0] REG_B1_X       = 3'd1;
    localparam logic [2:0] REG_B1_Y       = 3'd2;
    localparam logic [2:0] REG_B2_X       = 3'd3;
    localparam logic [2:0] REG_B2_Y       = 3'd4;
    localparam logic [2:0] REG_B3_X       = 3'd5;
    localparam logic [2:0] REG_B3_Y       = 3'd6;

    localparam logic [2:0] REGION_RED     = 3'd0;
    localparam logic [2:0] REGION_YELLOW  = 3'd1;
    localparam logic [2:0] REGION_GREEN   = 3'd2;
    localparam logic [2:0] REGION_CYAN    = 3'd3;
    localparam logic [2:0] REGION_BLUE    = 3'd4;
    localparam logic [2:0] REGION_MAGENTA = 3'd5;

    typedef logic [CENTRE_W-1:0] t_centre;
    typedef logic signed [DELTA_W-1:0] t_delta;

    typedef struct packed {
        logic [CENTRE_W-1:0] x;
        logic [CENTRE_W-1:0] y;
    } t_ball;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [7:0]         hue;
    } t_meta;

    typedef struct packed {
        t_meta                  meta;
        t_delta [NUM_BALLS-1:0] dx;
        t_delta [NUM_BALLS-1:0] dy;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_link;

    function automatic logic [2:0] hue_region(input logic [7:0] hue);
        logic [2:0] reg_n;
        reg_n = REGION_RED;
        if (hue >= HUE_SECTOR)          reg_n = REGION_YELLOW;
        if (hue >= 8'(2 * HUE_SECTOR))  reg_n = REGION_GREEN;
        if (hue >= 8'(3 * HUE_SECTOR))  reg_n = REGION_CYAN;
        if (hue >= 8'(4 * HUE_SECTOR))  reg_n = REGION_BLUE;
        if (hue >= 8'(5 * HUE_SECTOR))  reg_n = REGION_MAGENTA;
        return reg_n;
    endfunction

    function automatic logic [7:0] div_255(input logic [15:0] x);
        logic [32:0] m;
        m = {17'b0, x} * {16'b0, RECIP_255};
        return m[30:23];
    endfunction

endpackage

/* hdl/mfps_front.sv */
// front part: accepts a pixel, forms centre distances and the hue
// depends on mfps_pkg
module mfps_front (
    input  logic                          i_start,
    input  logic                          i_full,
    input  logic [mfps_pkg::COORD_W-1:0]  i_column,
    input  logic [mfps_pkg::COORD_W-1:0]  i_row,
    input  logic [7:0]                    i_hue_offset,
    input  mfps_pkg::t_ball [mfps_pkg::NUM_BALLS-1:0] i_balls,
    output mfps_pkg::t_link               o_link
);
    import mfps_pkg::*;

    logic [7:0] w_hue;

    assign w_hue = i_hue_offset + 8'(i_column) * 8'd3 + 8'(i_row) * 8'd9;

    always_comb begin
        o_link.valid            = i_start && !i_full;
        o_link.item.meta.column = i_column;
        o_link.item.meta.row    = i_row;
        o_link.item.meta.hue    = w_hue;
        for (int b = 0; b < NUM_BALLS; b++) begin
            o_link.item.dx[b] = t_delta'({1'b0, i_column, 8'b0}) - t_delta'({1'b0, i_balls[b].x});
            o_link.item.dy[b] = t_delta'({1'b0, i_row, 8'b0}) - t_delta'({1'b0, i_balls[b].y});
        end
    end

endmodule

/* hdl/mfps_fifo.sv */
// two-entry queue between front and back parts
// depends on mfps_pkg
module mfps_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mfps_pkg::t_link i_link,
    output logic            o_full,
    output mfps_pkg::t_link o_link
);
    import mfps_pkg::*;

    t_item      r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    logic       w_pop;

    assign w_pop  = r_count != 2'd0;
    assign o_full = r_count == 2'd2;
    assign o_link.valid = w_pop;
    assign o_link.item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_link.valid) r_mem[r_wptr] <= i_link.item;
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_link.valid) r_wptr <= ~r_wptr;
            if (w_pop) r_rptr <= ~r_rptr;
            r_count <= r_count + 2'(i_link.valid) - 2'(w_pop);
        end
    end

endmodule

/* hdl/mfps_back.sv */
// back part: squares, pipelined field divisions, brightness and hsv colour
// depends on mfps_pkg
module mfps_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mfps_pkg::t_link              i_link,
    output logic                         o_valid,
    output logic [mfps_pkg::COORD_W-1:0] o_column,
    output logic [mfps_pkg::COORD_W-1:0] o_row,
    output logic [7:0]                   o_red,
    output logic [7:0]                   o_green,
    output logic [7:0]                   o_blue
);
    import mfps_pkg::*;

    // squares
    logic                r_p1_vld;
    t_meta               r_p1_meta;
    logic [SQ_W-1:0]     r_sqx [NUM_BALLS];
    logic [SQ_W-1:0]     r_sqy [NUM_BALLS];
    // denominators
    logic                r_p2_vld;
    t_meta               r_p2_meta;
    logic [DEN_W-1:0]    r_den [NUM_BALLS];
    // divider stages
    logic                r_dv_vld  [DIV_STEPS];
    t_meta               r_dv_meta [DIV_STEPS];
    logic [DEN_W-1:0]    r_dv_rem  [NUM_BALLS][DIV_STEPS];
    logic [DEN_W-1:0]    r_dv_den  [NUM_BALLS][DIV_STEPS];
    logic [Q_W-1:0]      r_dv_q    [NUM_BALLS][DIV_STEPS];
    logic [DEN_W-1:0]    n_dv_rem  [NUM_BALLS][DIV_STEPS];
    logic [Q_W-1:0]      n_dv_q    [NUM_BALLS][DIV_STEPS];
    // brightness
    logic                r_p3_vld, r_p3_dark;
    t_meta               r_p3_meta;
    logic [7:0]          r_p3_v;
    // hue split
    logic                r_p4_vld, r_p4_dark;
    t_meta               r_p4_meta;
    logic [7:0]          r_p4_v, r_p4_rem;
    logic [2:0]          r_p4_region;
    // products
    logic                r_p5_vld, r_p5_dark;
    t_meta               r_p5_meta;
    logic [7:0]          r_p5_v;
    logic [2:0]          r_p5_region;
    logic [15:0]         r_p5_up, r_p5_dn;
    // output
    logic                r_out_vld;
    logic [COORD_W-1:0]  r_out_column, r_out_row;
    logic [7:0]          r_out_r, r_out_g, r_out_b;

    logic signed [2*DELTA_W-1:0] w_px [NUM_BALLS];
    logic signed [2*DELTA_W-1:0] w_py [NUM_BALLS];
    logic [SUM_W-1:0]    w_sum;
    logic [LEVEL_W-1:0]  w_level;
    logic [2:0]          w_region;
    logic [7:0]          w_rem;
    logic [7:0]          w_rise, w_fall;
    logic [7:0]          n_r, n_g, n_b;

    always_comb begin
        for (int b = 0; b < NUM_BALLS; b++) begin
            w_px[b] = i_link.item.dx[b] * i_link.item.dx[b];
            w_py[b] = i_link.item.dy[b] * i_link.item.dy[b];
        end
    end

    // one restoring step per stage, quotient bit from the top down
    always_comb begin
        logic [DEN_W:0]   rem2;
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] rem_in;
        logic [Q_W-1:0]   q_in;
        for (int b = 0; b < NUM_BALLS; b++) begin
            for (int s = 0; s < DIV_STEPS; s++) begin
                if (s == 0) begin
                    rem_in = REM_INIT;
                    q_in   = '0;
                    den    = r_den[b];
                end else begin
                    rem_in = r_dv_rem[b][s-1];
                    q_in   = r_dv_q[b][s-1];
                    den    = r_dv_den[b][s-1];
                end
                rem2 = {rem_in, 1'b0};
                if (rem2 >= {1'b0, den}) begin
                    n_dv_rem[b][s] = DEN_W'(rem2 - {1'b0, den});
                    n_dv_q[b][s]   = {q_in[Q_W-2:0], 1'b1};
                end else begin
                    n_dv_rem[b][s] = rem2[DEN_W-1:0];
                    n_dv_q[b][s]   = {q_in[Q_W-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        w_sum = '0;
        for (int b = 0; b < NUM_BALLS; b++) begin
            w_sum = w_sum + SUM_W'(r_dv_q[b][DIV_STEPS-1]);
        end
        w_level = w_sum[SUM_W-1:8];
    end

    assign w_region = hue_region(r_p3_meta.hue);
    assign w_rem    = (r_p3_meta.hue - 8'(w_region) * HUE_SECTOR) * 8'd6;
    assign w_rise   = div_255(r_p5_up);
    assign w_fall   = div_255(r_p5_dn);

    always_comb begin
        case (r_p5_region)
            REGION_YELLOW:  begin n_r = w_fall; n_g = r_p5_v; n_b = 8'd0;   end
            REGION_GREEN:   begin n_r = 8'd0;   n_g = r_p5_v; n_b = w_rise; end
            REGION_CYAN:    begin n_r = 8'd0;   n_g = w_fall; n_b = r_p5_v; end
            REGION_BLUE:    begin n_r = w_rise; n_g = 8'd0;   n_b = r_p5_v; end
            REGION_MAGENTA: begin n_r = r_p5_v; n_g = 8'd0;   n_b = w_fall; end
            default:        begin n_r = r_p5_v; n_g = w_rise; n_b = 8'd0;   end
        endcase
        if (r_p5_dark) begin
            n_r = 8'd0;
            n_g = 8'd0;
            n_b = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_meta <= i_link.item.meta;
        for (int b = 0; b < NUM_BALLS; b++) begin
            r_sqx[b] <= w_px[b][SQ_W-1:0];
            r_sqy[b] <= w_py[b][SQ_W-1:0];
            r_den[b] <= DEN_W'(r_sqx[b]) + DEN_W'(r_sqy[b]) + DEN_BIAS;
            for (int s = 0; s < DIV_STEPS; s++) begin
                r_dv_rem[b][s] <= n_dv_rem[b][s];
                r_dv_q[b][s]   <= n_dv_q[b][s];
                r_dv_den[b][s] <= (s == 0) ? r_den[b] : r_dv_den[b][s-1];
            end
        end
        r_p2_meta <= r_p1_meta;
        for (int s = 0; s < DIV_STEPS; s++) begin
            r_dv_meta[s] <= (s == 0) ? r_p2_meta : r_dv_meta[s-1];
        end
        r_p3_meta <= r_dv_meta[DIV_STEPS-1];
        r_p3_dark <= w_level < DARK_LEVEL;
        r_p3_v    <= (w_level > LEVEL_W'(MAX_LEVEL)) ? MAX_LEVEL : w_level[7:0];
        r_p4_meta   <= r_p3_meta;
        r_p4_dark   <= r_p3_dark;
        r_p4_v      <= r_p3_v;
        r_p4_rem    <= w_rem;
        r_p4_region <= w_region;
        r_p5_meta   <= r_p4_meta;
        r_p5_dark   <= r_p4_dark;
        r_p5_v      <= r_p4_v;
        r_p5_region <= r_p4_region;
        r_p5_up     <= {8'b0, r_p4_v} * {8'b0, r_p4_rem};
        r_p5_dn     <= {8'b0, r_p4_v} * {8'b0, MAX_LEVEL - r_p4_rem};
        r_out_column <= r_p5_meta.column;
        r_out_row    <= r_p5_meta.row;
        r_out_r      <= n_r;
        r_out_g      <= n_g;
        r_out_b      <= n_b;
        if (!i_rst_n) begin
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_p3_vld  <= 1'b0;
            r_p4_vld  <= 1'b0;
            r_p5_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int s = 0; s < DIV_STEPS; s++) r_dv_vld[s] <= 1'b0;
        end else begin
            r_p1_vld <= i_link.valid;
            r_p2_vld <= r_p1_vld;
            for (int s = 0; s < DIV_STEPS; s++) begin
                r_dv_vld[s] <= (s == 0) ? r_p2_vld : r_dv_vld[s-1];
            end
            r_p3_vld  <= r_dv_vld[DIV_STEPS-1];
            r_p4_vld  <= r_p3_vld;
            r_p5_vld  <= r_p4_vld;
            r_out_vld <= r_p5_vld;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_column = r_out_column;
    assign o_row    = r_out_row;
    assign o_red    = r_out_r;
    assign o_green  = r_out_g;
    assign o_blue   = r_out_b;

endmodule

/* hdl/metaball_field_pixel_shader.sv */
// top level of the metaball field pixel shader: register file and the parts
// depends on mfps_pkg, mfps_front, mfps_fifo, mfps_back
//
// channel   | handshake                     | payload
// ----------+-------------------------------+------------------------------
// pixel in  | start & !busy                 | i_column, i_row
// colour out| o_valid (one cycle, no stall) | o_column_out, o_row_out, rgb
// config    | psel & penable & pwrite       | paddr (4*index), pwdata
//
// one pixel per clock sustained; from accept to o_valid each transaction
// passes the queue, square, denominator, the 17 stage restoring divider per
// ball, then level, hue split, product and colour stages
// reset is synchronous and active low; it clears the queue and stage valids
// and loads the default ball centres and hue offset
// busy rises only if the queue fills, which cannot happen since the back
// part drains one transaction a cycle and the receiver never stalls
module metaball_field_pixel_shader (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_column,
    input  logic [3:0]  i_row,
    output logic        o_valid,
    output logic [3:0]  o_column_out,
    output logic [3:0]  o_row_out,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mfps_pkg::*;

    logic [7:0]                  r_hue_offset;
    t_ball [NUM_BALLS-1:0]       r_balls;
    logic                        w_wr;
    logic [2:0]                  w_idx;
    logic                        w_full;
    t_link                       w_front_link, w_back_link;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:2];

    // register file, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_offset <= 8'd0;
            for (int b = 0; b < NUM_BALLS; b++) begin
                r_balls[b].x <= CENTRE_W'(1920);
                r_balls[b].y <= CENTRE_W'(1920);
            end
        end else if (w_wr) begin
            case (w_idx)
                REG_HUE_OFFSET: r_hue_offset <= pwdata[7:0];
                REG_B1_X:       r_balls[0].x <= pwdata[CENTRE_W-1:0];
                REG_B1_Y:       r_balls[0].y <= pwdata[CENTRE_W-1:0];
                REG_B2_X:       r_balls[1].x <= pwdata[CENTRE_W-1:0];
                REG_B2_Y:       r_balls[1].y <= pwdata[CENTRE_W-1:0];
                REG_B3_X:       r_balls[2].x <= pwdata[CENTRE_W-1:0];
                REG_B3_Y:       r_balls[2].y <= pwdata[CENTRE_W-1:0];
                default:        ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (w_idx)
            REG_HUE_OFFSET: prdata = {24'b0, r_hue_offset};
            REG_B1_X:       prdata = {20'b0, r_balls[0].x};
            REG_B1_Y:       prdata = {20'b0, r_balls[0].y};
            REG_B2_X:       prdata = {20'b0, r_balls[1].x};
            REG_B2_Y:       prdata = {20'b0, r_balls[1].y};
            REG_B3_X:       prdata = {20'b0, r_balls[2].x};
            REG_B3_Y:       prdata = {20'b0, r_balls[2].y};
            default:        prdata = 32'b0;
        endcase
    end

    assign busy = w_full;

    // front part forms distances and hue at accept
    mfps_front u_front (
        .i_start      (start),
        .i_full       (w_full),
        .i_column     (i_column),
        .i_row        (i_row),
        .i_hue_offset (r_hue_offset),
        .i_balls      (r_balls),
        .o_link       (w_front_link)
    );

    // short queue decouples accept from the math pipeline
    mfps_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_link  (w_front_link),
        .o_full  (w_full),
        .o_link  (w_back_link)
    );

    // back part computes field, brightness and colour
    mfps_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_link   (w_back_link),
        .o_valid  (o_valid),
        .o_column (o_column_out),
        .o_row    (o_row_out),
        .o_red    (o_red),
        .o_green  (o_green),
        .o_blue   (o_blue)
    );

endmodule

/* tb/sv/testbench.sv */
// self-checking testbench of the metaball field pixel shader
// depends on mfps_pkg and metaball_field_pixel_shader; predicts each pixel colour
// from the ball centres and hue offset written over the apb port

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mfps_pkg::*;

    // pixel transaction and expected colour
    typedef struct {
        logic [3:0] column;
        logic [3:0] row;
    } t_pixel;

    typedef struct {
        logic [3:0] column;
        logic [3:0] row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_colour;

    localparam int PIPE_DRAIN = 40;
    // index with no register behind it
    localparam logic [2:0] REG_NONE = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [3:0]  i_column;
    logic [3:0]  i_row;
    logic        o_valid;
    logic [3:0]  o_column_out;
    logic [3:0]  o_row_out;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // model copy of the register file
    logic [7:0]  hue_rot;
    logic [11:0] centre_x [NUM_BALLS];
    logic [11:0] centre_y [NUM_BALLS];

    t_pixel  pending_pixels [$];
    t_colour colours_due [$];
    int      error_count;
    bit      stimulus_done;
    int      gap_left;

    metaball_field_pixel_shader dut (.*);

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // sum of the three q8 field terms, truncated to an integer level
    function automatic logic [31:0] field_level(input logic [3:0] col, input logic [3:0] rw);
        longint dx;
        longint dy;
        longint den;
        longint total;
        total = 0;
        for (int k = 0; k < NUM_BALLS; k++) begin
            dx = longint'({col, 8'h00}) - longint'(centre_x[k]);
            dy = longint'({rw, 8'h00}) - longint'(centre_y[k]);
            den = dx * dx + dy * dy + 4 * 65536;
            total += (longint'(1260) <<< 24) / den;
        end
        return 32'(total >>> 8);
    endfunction

    function automatic t_colour shade_pixel(input t_pixel px);
        t_colour c;
        logic [31:0] level;
        int v, hue, region, rem, rising, falling;
        c.column = px.column;
        c.row = px.row;
        c.red = 8'd0;
        c.green = 8'd0;
        c.blue = 8'd0;
        level = field_level(px.column, px.row);
        if (level >= 40) begin
            v = (level > 255) ? 255 : int'(level);
            hue = (int'(hue_rot) + 3 * int'(px.column) + 9 * int'(px.row)) % 256;
            region = hue / 43;
            rem = (hue - region * 43) * 6;
            rising = v * rem / 255;
            falling = v * (255 - rem) / 255;
            case (region)
                1: begin c.red = 8'(falling); c.green = 8'(v); end
                2: begin c.green = 8'(v); c.blue = 8'(rising); end
                3: begin c.green = 8'(falling); c.blue = 8'(v); end
                4: begin c.red = 8'(rising); c.blue = 8'(v); end
                5: begin c.red = 8'(v); c.blue = 8'(falling); end
                default: begin c.red = 8'(v); c.green = 8'(rising); end
            endcase
        end
        return c;
    endfunction

    // mostly short gaps, now and then a long one, sometimes runs without gaps
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return 0;
        if (sel < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // driver: one pixel transaction per accept, random gaps between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left <= 0;
        end else if (start && busy) begin
            // hold the pixel until the block takes it
        end else begin
            if (start) begin
                colours_due.push_back(shade_pixel('{i_column, i_row}));
            end
            if (gap_left > 0 || pending_pixels.size() == 0) begin
                start <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
                t_pixel px;
                px = pending_pixels.pop_front();
                start <= 1'b1;
                i_column <= px.column;
                i_row <= px.row;
                gap_left <= pick_gap();
            end
        end
    end

    // monitor: every colour transaction against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (colours_due.size() == 0) begin
                $error("colour with no pixel pending: col %0d row %0d",
                       o_column_out, o_row_out);
                error_count++;
            end else begin
                t_colour want;
                want = colours_due.pop_front();
                if (o_column_out !== want.column) begin
                    $error("column_out expected %0d actual %0d", want.column, o_column_out);
                    error_count++;
                end
                if (o_row_out !== want.row) begin
                    $error("row_out expected %0d actual %0d", want.row, o_row_out);
                    error_count++;
                end
                if (o_red !== want.red) begin
                    $error("red expected %0d actual %0d", want.red, o_red);
                    error_count++;
                end
                if (o_green !== want.green) begin
                    $error("green expected %0d actual %0d", want.green, o_green);
                    error_count++;
                end
                if (o_blue !== want.blue) begin
                    $error("blue expected %0d actual %0d", want.blue, o_blue);
                    error_count++;
                end
            end
        end
    end

    // apb write: setup then access phase, model updated on the access edge
    task automatic reg_write(input logic [2:0] index, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            REG_HUE_OFFSET: hue_rot = value[7:0];
            REG_B1_X: centre_x[0] = value[11:0];
            REG_B1_Y: centre_y[0] = value[11:0];
            REG_B2_X: centre_x[1] = value[11:0];
            REG_B2_Y: centre_y[1] = value[11:0];
            REG_B3_X: centre_x[2] = value[11:0];
            REG_B3_Y: centre_y[2] = value[11:0];
            default: ;
        endcase
    endtask

    task automatic set_frame(input logic [7:0] hue, input logic [11:0] cx [NUM_BALLS],
                             input logic [11:0] cy [NUM_BALLS]);
        reg_write(REG_HUE_OFFSET, {24'b0, hue});
        reg_write(REG_B1_X, {20'b0, cx[0]});
        reg_write(REG_B1_Y, {20'b0, cy[0]});
        reg_write(REG_B2_X, {20'b0, cx[1]});
        reg_write(REG_B2_Y, {20'b0, cy[1]});
        reg_write(REG_B3_X, {20'b0, cx[2]});
        reg_write(REG_B3_Y, {20'b0, cy[2]});
    endtask

    // let the pipeline empty before touching the registers
    task automatic drain();
        while (pending_pixels.size() != 0 || start || colours_due.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    task automatic queue_pixel(input logic [3:0] col, input logic [3:0] rw);
        pending_pixels.push_back('{col, rw});
    endtask

    initial begin
        logic [11:0] cx [NUM_BALLS];
        logic [11:0] cy [NUM_BALLS];
        int span;
        error_count = 0;
        stimulus_done = 0;
        hue_rot = 8'd0;
        for (int k = 0; k < NUM_BALLS; k++) begin
            centre_x[k] = 12'd1920;
            centre_y[k] = 12'd1920;
        end
        i_rst_n = 1'b0;
        start = 1'b0;
        i_column = 4'd0;
        i_row = 4'd0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 5'd0;
        pwdata = 32'd0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: corners and centre on reset centres (bright and dim pixels)
        queue_pixel(4'd0, 4'd0);
        queue_pixel(4'd15, 4'd15);
        queue_pixel(4'd0, 4'd15);
        queue_pixel(4'd15, 4'd0);
        queue_pixel(4'd7, 4'd7);
        queue_pixel(4'd8, 4'd7);
        queue_pixel(4'd7, 4'd8);
        queue_pixel(4'd6, 4'd6);
        drain();

        // balls spread out, hue offset at top, walk through every hue region
        cx = '{12'd0, 12'd3840, 12'd1024};
        cy = '{12'd0, 12'd3840, 12'd2816};
        set_frame(8'd255, cx, cy);
        for (int i = 0; i < 16; i++) queue_pixel(4'(i), 4'(i));
        drain();

        // centres past the last pixel and an unknown register index
        cx = '{12'hFFF, 12'hFFF, 12'd0};
        cy = '{12'hFFF, 12'd0, 12'hFFF};
        set_frame(8'd0, cx, cy);
        reg_write(REG_NONE, 32'hFFFF_FFFF);
        queue_pixel(4'd15, 4'd15);
        queue_pixel(4'd0, 4'd0);
        queue_pixel(4'd15, 4'd0);
        drain();

        // random frames: centres within the pixel grid, every third frame anywhere
        for (int f = 0; f < 30; f++) begin
            for (int k = 0; k < NUM_BALLS; k++) begin
                if (f % 3 == 0) begin
                    cx[k] = 12'($urandom_range(0, 4095));
                    cy[k] = 12'($urandom_range(0, 4095));
                end else begin
                    cx[k] = 12'($urandom_range(0, 3840));
                    cy[k] = 12'($urandom_range(0, 3840));
                end
            end
            set_frame(8'($urandom_range(0, 255)), cx, cy);
            span = $urandom_range(32, 52);
            for (int i = 0; i < span; i++)
                queue_pixel(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
            drain();
        end

        // back to reset-like centres with a full raster scan
        cx = '{12'd1920, 12'd1920, 12'd1920};
        cy = '{12'd1920, 12'd1920, 12'd1920};
        set_frame(8'd128, cx, cy);
        for (int r = 0; r < 16; r++)
            for (int c = 0; c < 16; c++) queue_pixel(4'(c), 4'(r));
        drain();

        stimulus_done = 1;
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog well above the slowest correct run
    initial begin
        #3ms;
        $display("simulation failed");
        $finish;
    end

endmodule

/* metaball_field_pixel_shader.f */
hdl/mfps_pkg.sv
hdl/mfps_front.sv
hdl/mfps_fifo.sv
hdl/mfps_back.sv
hdl/metaball_field_pixel_shader.sv
tb/sv/testbench.sv
